>>> design/sequence_reorder_buffer_unit_macros.svh
// ----------------------------------------------------------------------------
// Sequence reorder buffer assertion macros
// Shared concurrent assertion forms for the reorder buffer checkers.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH
`define SEQUENCE_REORDER_BUFFER_UNIT_MACROS_SVH

// checked outside reset
`define SRB_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked in and out of reset
`define SRB_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/srb_pkg.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer package
// Widths, request and response payloads, controller states.
// ----------------------------------------------------------------------------
package srb_pkg;

   localparam int SEQ_W = 32;
   localparam int TAG_W = 32;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      logic [TAG_W-1:0] item_tag;
   } srb_req_type;

   typedef enum logic {
      SRB_RELEASED = 1'b0,
      SRB_REJECTED = 1'b1
   } srb_status_type;

   typedef struct packed {
      srb_status_type   status;
      logic [SEQ_W-1:0] out_seq;
      logic [TAG_W-1:0] out_tag;
      logic             last;
   } srb_rsp_type;

   // per-cell controls from the controller
   typedef struct packed {
      logic write;
      logic shift;
   } srb_cell_ctrl_type;

   typedef enum logic {
      SRB_IDLE,
      SRB_DRAIN
   } srb_state_type;

endpackage

>>> design/srb_stream_if.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer stream interface
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface srb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> design/sequence_reorder_buffer_unit.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer unit
// Restores sequence order of completed items through a window of cells.
// ----------------------------------------------------------------------------
// Each request carries a 32-bit sequence number and a tag. A number within
// WINDOW places of the expected one (mod 2^32) stores its tag in the cell for
// that distance; anything else is answered at once by a single reject
// response (status 1, last 1). Cell 0 always belongs to the expected number.
// After a store the unit drains: while cell 0 is occupied it sends that tag
// as a released response and the whole row of cells steps down by one, so
// the expected number advances with it. The last response of a burst has
// last set; a store that leaves a gap at the expected number gives nothing.
// A reject is answered straight from the idle state. A store passes through an
// insert step and then the drain, which releases one item per shift of the
// cell row and waits while the response register is full and not consumed. A
// store that releases nothing still enters the drain, which finds the gap.
// No request is taken during a drain. Responses sit in an output register, so
// a request may be taken in the cycle the previous response is consumed. All
// cells are cleared by reset; there is no clearing pass.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_unit #(
   parameter int WINDOW = 16
) (
   input  logic          clock,
   input  logic          reset,
   srb_stream_if.sink    req_if,
   srb_stream_if.source  rsp_if
);
   import srb_pkg::*;

   localparam int IDX_W = $clog2(WINDOW);

   // cell row
   logic                    cell_valid [WINDOW];
   logic [TAG_W-1:0]        cell_tag   [WINDOW];
   srb_cell_ctrl_type       cell_ctrl  [WINDOW];

   // controller
   srb_state_type           state_ff, state_in;
   logic [SEQ_W-1:0]        expected_ff;
   logic                    rsp_valid_ff;
   srb_rsp_type             rsp_payload_ff;

   logic [SEQ_W-1:0]        offset;
   logic                    in_window;
   logic                    req_ready;
   logic                    req_fire;
   logic                    rsp_free;
   logic                    drain_fire;

   // distance from the expected number, wrapping
   assign offset    = req_if.payload.seq_num - expected_ff;
   assign in_window = offset < SEQ_W'(WINDOW);
   assign rsp_free  = !rsp_valid_ff || rsp_if.ready;
   assign req_fire  = req_if.valid && req_ready;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      drain_fire = 1'b0;
      case (state_ff)
         SRB_IDLE: begin
            // a reject goes straight into the response register
            req_ready = rsp_free;
            if (req_if.valid && rsp_free && in_window) begin
               state_in = SRB_DRAIN;
            end
         end
         SRB_DRAIN: begin
            if (!cell_valid[0]) begin
               state_in = SRB_IDLE;          // gap at expected number
            end else if (rsp_free) begin
               drain_fire = 1'b1;
               if (!cell_valid[1]) begin
                  state_in = SRB_IDLE;       // this one is last
               end
            end
         end
         default: begin
            state_in = SRB_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SRB_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= '0;
      end else if (drain_fire) begin
         expected_ff <= expected_ff + SEQ_W'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((req_fire && !in_window) || drain_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !in_window) begin
         rsp_payload_ff.status  <= SRB_REJECTED;
         rsp_payload_ff.out_seq <= req_if.payload.seq_num;
         rsp_payload_ff.out_tag <= req_if.payload.item_tag;
         rsp_payload_ff.last    <= 1'b1;
      end else if (drain_fire) begin
         rsp_payload_ff.status  <= SRB_RELEASED;
         rsp_payload_ff.out_seq <= expected_ff;
         rsp_payload_ff.out_tag <= cell_tag[0];
         rsp_payload_ff.last    <= !cell_valid[1];
      end
   end

   // row of cells; cell i holds expected number + i
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      logic             nb_valid;
      logic [TAG_W-1:0] nb_tag;

      if (i == WINDOW - 1) begin : g_end
         assign nb_valid = 1'b0;
         assign nb_tag   = '0;
      end else begin : g_mid
         assign nb_valid = cell_valid[i+1];
         assign nb_tag   = cell_tag[i+1];
      end

      assign cell_ctrl[i].write = req_fire && in_window &&
                                  (offset[IDX_W-1:0] == IDX_W'(i));
      assign cell_ctrl[i].shift = drain_fire;

      srb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl[i]),
         .wr_tag   (req_if.payload.item_tag),
         .nb_valid (nb_valid),
         .nb_tag   (nb_tag),
         .valid    (cell_valid[i]),
         .tag      (cell_tag[i])
      );
   end

   assign req_if.ready   = req_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

endmodule

>>> design/srb_cell.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer cell
// One window place: valid bit and tag, loaded on insert or from its neighbour.
// ----------------------------------------------------------------------------
module srb_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  srb_pkg::srb_cell_ctrl_type ctrl,
   input  logic [srb_pkg::TAG_W-1:0] wr_tag,
   input  logic                      nb_valid,
   input  logic [srb_pkg::TAG_W-1:0] nb_tag,
   output logic                      valid,
   output logic [srb_pkg::TAG_W-1:0] tag
);
   import srb_pkg::*;

   logic             valid_ff;
   logic [TAG_W-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.write) begin
         valid_ff <= 1'b1;
      end else if (ctrl.shift) begin
         valid_ff <= nb_valid;
      end
   end

   // overwrite on repeated number
   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         tag_ff <= wr_tag;
      end else if (ctrl.shift) begin
         tag_ff <= nb_tag;
      end
   end

   assign valid = valid_ff;
   assign tag   = tag_ff;

endmodule

>>> design/srb_checker.sv
// ----------------------------------------------------------------------------
// Sequence reorder buffer checker
// Port-level assertions on the reorder buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequence_reorder_buffer_unit_macros.svh"

module srb_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input srb_pkg::srb_rsp_type rsp_payload
);
   import srb_pkg::*;

   // stalled response holds
   `SRB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "response changed while stalled")

   // a reject is always a burst of one
   `SRB_ASSERT(a_reject_last, rsp_valid && (rsp_payload.status == SRB_REJECTED) |-> rsp_payload.last, "reject without last")

   // no request taken inside an open burst
   `SRB_ASSERT(a_burst_closed, rsp_valid && rsp_ready && !rsp_payload.last |-> !(req_valid && req_ready), "request taken mid burst")

   // reset empties the response register
   `SRB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind sequence_reorder_buffer_unit srb_checker u_srb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
